// ----- rtl/itp_pkg.sv -----
// itp_pkg: shared types, constants and helpers of the infix to postfix converter
// used by itp_stack, infix_to_postfix_converter and the bench; no dependencies
`default_nettype none

package itp_pkg;

    // operator stack geometry
    localparam int STACK_DEPTH = 32;
    localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);
    localparam int PTR_W       = $clog2(STACK_DEPTH);

    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [PTR_W-1:0]   ptr_t;
    typedef logic [7:0]         char_t;
    typedef logic [1:0]         prio_t;

    // command codes
    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // characters with a meaning of their own
    localparam char_t CHAR_OPEN  = 8'h28;
    localparam char_t CHAR_CLOSE = 8'h29;
    localparam char_t CHAR_POW   = 8'h24;
    localparam char_t CHAR_PLUS  = 8'h2B;
    localparam char_t CHAR_MINUS = 8'h2D;
    localparam char_t CHAR_MUL   = 8'h2A;
    localparam char_t CHAR_DIV   = 8'h2F;
    localparam char_t CHAR_MOD   = 8'h25;
    localparam char_t CHAR_NL    = 8'h0A;
    localparam char_t CHAR_0     = 8'h30;
    localparam char_t CHAR_9     = 8'h39;
    localparam char_t CHAR_UA    = 8'h41;
    localparam char_t CHAR_UZ    = 8'h5A;
    localparam char_t CHAR_LA    = 8'h61;
    localparam char_t CHAR_LZ    = 8'h7A;

    // request to the stack, one per cycle
    typedef struct packed {
        logic  push;
        logic  pop;
        char_t data;
    } stk_op_t;

    // stack status seen by the sequencer
    typedef struct packed {
        char_t top;
        logic  empty;
        logic  full;
        logic  no_open;
    } stk_stat_t;

    // operator priority
    function automatic prio_t prio(input char_t c);
        prio_t p;
        if (c == CHAR_OPEN)
            p = 2'd0;
        else if (c == CHAR_PLUS || c == CHAR_MINUS)
            p = 2'd1;
        else if (c == CHAR_MUL || c == CHAR_DIV || c == CHAR_MOD)
            p = 2'd2;
        else
            p = 2'd3;
        return p;
    endfunction

    // ascii letter or digit
    function automatic logic is_alnum(input char_t c);
        return (c >= CHAR_0 && c <= CHAR_9) || (c >= CHAR_UA && c <= CHAR_UZ) ||
               (c >= CHAR_LA && c <= CHAR_LZ);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/itp_in_if.sv -----
// itp_in_if: input channel of the converter, one infix character or end command per beat
// no dependencies
`default_nettype none

interface itp_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] in_char;

    modport source (output valid, cmd, in_char, input ready);
    modport sink   (input valid, cmd, in_char, output ready);
endinterface

`default_nettype wire

// ----- rtl/itp_out_if.sv -----
// itp_out_if: output channel of the converter, one postfix character per beat
// no dependencies
`default_nettype none

interface itp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last;
    logic       error;

    modport source (output valid, out_char, last, error, input ready);
    modport sink   (input valid, out_char, last, error, output ready);
endinterface

`default_nettype wire

// ----- rtl/itp_stack.sv -----
// itp_stack: operator stack with fill level and count of open parentheses held
// depends on itp_pkg
`default_nettype none

module itp_stack (
    input  logic              clk,
    input  logic              rst_n,
    input  itp_pkg::stk_op_t  op,
    output itp_pkg::stk_stat_t stat
);
    import itp_pkg::*;

    char_t  stack_mem [STACK_DEPTH];
    level_t level_reg;
    level_t level_next;
    level_t open_cnt_reg;
    level_t open_cnt_next;
    char_t  top_reg;
    ptr_t   below_idx;
    logic   do_push;
    logic   do_pop;

    // entry under the top sits two below the fill level
    assign below_idx    = ptr_t'(level_reg - level_t'(2));
    assign stat.top     = top_reg;
    assign stat.empty   = (level_reg == level_t'(0));
    assign stat.full    = (level_reg == level_t'(STACK_DEPTH));
    assign stat.no_open = (open_cnt_reg == level_t'(0));

    assign do_push = op.push && !stat.full;
    assign do_pop  = op.pop && !stat.empty;

    // level and parenthesis count
    always_comb
    begin
        level_next    = level_reg;
        open_cnt_next = open_cnt_reg;
        if (do_push)
        begin
            level_next = level_reg + level_t'(1);
            if (op.data == CHAR_OPEN)
                open_cnt_next = open_cnt_reg + level_t'(1);
        end
        else if (do_pop)
        begin
            level_next = level_reg - level_t'(1);
            if (stat.top == CHAR_OPEN)
                open_cnt_next = open_cnt_reg - level_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg    <= '0;
            open_cnt_reg <= '0;
        end
        else
        begin
            level_reg    <= level_next;
            open_cnt_reg <= open_cnt_next;
        end
    end

    // entry storage and registered copy of the top entry, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            stack_mem[level_reg[PTR_W-1:0]] <= op.data;
            top_reg                         <= op.data;
        end
        else if (do_pop)
        begin
            top_reg <= stack_mem[below_idx];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/infix_to_postfix_converter.sv -----
// infix_to_postfix_converter: shunting-yard conversion of an infix character stream
// depends on itp_pkg, itp_in_if, itp_out_if and itp_stack
//
//  channel   | dir | payload                | beat
//  ----------+-----+------------------------+------------------------------------
//  char_in   | in  | cmd, in_char           | one infix character or end command
//  char_out  | out | out_char, last, error  | one postfix character
//
// a letter or digit is sent from S_FLUSH; an operator or ')' pops in S_OPER or
// S_CLOSE, then S_FLUSH; an end command drains each entry held in S_END
// the stack gives one pop per cycle, output permitting, via a registered top copy
// '(' is pushed in the accepting cycle
// reset empties the stack and clears the error flag at once, no clearing pass
// a stalled output holds the sequencer; char_in is ready only between items
`default_nettype none

module infix_to_postfix_converter (
    input  logic     clk,
    input  logic     rst_n,
    itp_in_if.sink   char_in,
    itp_out_if.source char_out
);
    import itp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OPER,
        S_CLOSE,
        S_END,
        S_FLUSH
    } state_t;

    state_t    state_reg, state_next;
    char_t     char_reg, char_next;
    logic      err_item_reg, err_item_next;
    logic      error_seen_reg, error_seen_next;
    char_t     pend_reg, pend_next;
    logic      pend_valid_reg, pend_valid_next;
    logic      out_valid_reg, out_valid_next;
    char_t     out_char_reg, out_char_next;
    logic      out_last_reg, out_last_next;
    logic      out_err_reg, out_err_next;

    stk_op_t   stk_op;
    stk_stat_t stk_stat;

    logic      in_beat;
    logic      slot_free;
    logic      pop_wins;
    prio_t     top_prio;
    prio_t     char_prio;

    itp_stack u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (stk_op),
        .stat  (stk_stat)
    );

    assign char_in.ready   = (state_reg == S_IDLE);
    assign in_beat         = char_in.valid && char_in.ready;
    assign char_out.valid    = out_valid_reg;
    assign char_out.out_char = out_char_reg;
    assign char_out.last     = out_last_reg;
    assign char_out.error    = out_err_reg;

    // output register can take a beat this cycle
    assign slot_free = !out_valid_reg || char_out.ready;

    // priority compare of stack top against the held operator
    assign top_prio  = prio(stk_stat.top);
    assign char_prio = prio(char_reg);
    assign pop_wins  = (char_reg == CHAR_POW) ? (top_prio > char_prio)
                                              : (top_prio >= char_prio);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        char_next       = char_reg;
        err_item_next   = err_item_reg;
        error_seen_next = error_seen_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg && !char_out.ready;
        out_char_next   = out_char_reg;
        out_last_next   = out_last_reg;
        out_err_next    = out_err_reg;
        stk_op.push     = 1'b0;
        stk_op.pop      = 1'b0;
        stk_op.data     = char_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    char_next     = char_in.in_char;
                    err_item_next = error_seen_reg;
                    if (char_in.cmd == CMD_END)
                    begin
                        error_seen_next = 1'b0;
                        state_next      = S_END;
                    end
                    else if (is_alnum(char_in.in_char))
                    begin
                        pend_next       = char_in.in_char;
                        pend_valid_next = 1'b1;
                        state_next      = S_FLUSH;
                    end
                    else if (char_in.in_char == CHAR_OPEN)
                    begin
                        // push now, no results
                        stk_op.push = 1'b1;
                        stk_op.data = char_in.in_char;
                        if (stk_stat.full)
                            error_seen_next = 1'b1;
                    end
                    else if (char_in.in_char == CHAR_CLOSE)
                    begin
                        // unmatched ')' is known up front from the open count
                        if (stk_stat.no_open)
                        begin
                            error_seen_next = 1'b1;
                            err_item_next   = 1'b1;
                        end
                        state_next = S_CLOSE;
                    end
                    else
                    begin
                        state_next = S_OPER;
                    end
                end
            end

            S_OPER:
            begin
                if (slot_free)
                begin
                    if (!stk_stat.empty && pop_wins)
                    begin
                        stk_op.pop      = 1'b1;
                        pend_next       = stk_stat.top;
                        pend_valid_next = 1'b1;
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_char_next  = pend_reg;
                            out_last_next  = 1'b0;
                            out_err_next   = err_item_reg;
                        end
                    end
                    else
                    begin
                        stk_op.push = 1'b1;
                        if (stk_stat.full)
                            error_seen_next = 1'b1;
                        state_next = S_FLUSH;
                    end
                end
            end

            S_CLOSE:
            begin
                if (slot_free)
                begin
                    if (stk_stat.empty)
                    begin
                        state_next = S_FLUSH;
                    end
                    else if (stk_stat.top == CHAR_OPEN)
                    begin
                        // matching '(' is dropped
                        stk_op.pop = 1'b1;
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        stk_op.pop      = 1'b1;
                        pend_next       = stk_stat.top;
                        pend_valid_next = 1'b1;
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_char_next  = pend_reg;
                            out_last_next  = 1'b0;
                            out_err_next   = err_item_reg;
                        end
                    end
                end
            end

            S_END:
            begin
                if (slot_free)
                begin
                    // drain top first, then the newline
                    pend_valid_next = 1'b1;
                    if (!stk_stat.empty)
                    begin
                        stk_op.pop = 1'b1;
                        pend_next  = stk_stat.top;
                    end
                    else
                    begin
                        pend_next  = CHAR_NL;
                        state_next = S_FLUSH;
                    end
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_char_next  = pend_reg;
                        out_last_next  = 1'b0;
                        out_err_next   = err_item_reg;
                    end
                end
            end

            S_FLUSH:
            begin
                // held result is the final beat of this item
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_char_next   = pend_reg;
                    out_last_next   = 1'b1;
                    out_err_next    = err_item_reg;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            error_seen_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            char_reg       <= '0;
            err_item_reg   <= 1'b0;
            pend_reg       <= '0;
            out_char_reg   <= '0;
            out_last_reg   <= 1'b0;
            out_err_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            error_seen_reg <= error_seen_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            char_reg       <= char_next;
            err_item_reg   <= err_item_next;
            pend_reg       <= pend_next;
            out_char_reg   <= out_char_next;
            out_last_reg   <= out_last_next;
            out_err_reg    <= out_err_next;
        end
    end

`ifndef SYNTH
    // nothing is held back between items
    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !pend_valid_reg)
        else $error("pending result left over in idle");

    // sequencer never pops an empty stack
    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        stk_op.pop |-> !stk_stat.empty)
        else $error("pop of an empty stack");

    // push and pop never share a cycle
    a_push_pop_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(stk_op.push && stk_op.pop))
        else $error("push and pop in the same cycle");

    // end command leaves the error flag clear
    a_end_clears_err: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && char_in.cmd == CMD_END |=> !error_seen_reg)
        else $error("error flag survives an end command");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_infix_to_postfix_converter.sv -----
// tb_infix_to_postfix_converter: self-checking bench of the shunting-yard converter
// depends on itp_pkg, itp_in_if, itp_out_if and infix_to_postfix_converter
// a directed table then random stimulus, postfix beats checked against a predictor or a row
`default_nettype none

module tb_infix_to_postfix_converter;
    timeunit 1ns;
    timeprecision 1ps;

    import itp_pkg::*;

    // how a stimulus row is checked
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_ONE
    } chk_kind_e;

    typedef struct packed {
        logic      cmd;
        char_t     ch;
        chk_kind_e chk;
        char_t     exp_char;
        logic      exp_err;
    } infix_beat_t;

    typedef struct packed {
        char_t out_char;
        logic  last;
        logic  err;
    } postfix_beat_t;

    localparam int DIR_N       = 25;
    localparam int RANDOM_GOAL = 500;

    logic clk = 1'b0;
    logic rst_n;

    itp_in_if  char_in ();
    itp_out_if char_out ();

    infix_to_postfix_converter u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .char_in  (char_in),
        .char_out (char_out)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // directed rows: extremes, every operator and the special cases
    infix_beat_t directed_tbl [DIR_N] = '{
        '{CMD_CHAR, "a",        CHK_ONE,   "a",        1'b0},
        '{CMD_END,  8'h00,      CHK_ONE,   CHAR_NL,    1'b0},
        '{CMD_CHAR, CHAR_CLOSE, CHK_NONE,  8'h00,      1'b0},
        '{CMD_CHAR, "Z",        CHK_ONE,   "Z",        1'b1},
        '{CMD_END,  8'hFF,      CHK_ONE,   CHAR_NL,    1'b1},
        '{CMD_CHAR, "0",        CHK_ONE,   "0",        1'b0},
        '{CMD_CHAR, "9",        CHK_ONE,   "9",        1'b0},
        '{CMD_CHAR, "z",        CHK_ONE,   "z",        1'b0},
        '{CMD_CHAR, "A",        CHK_ONE,   "A",        1'b0},
        '{CMD_CHAR, 8'hFF,      CHK_NONE,  8'h00,      1'b0},
        '{CMD_CHAR, 8'h00,      CHK_MODEL, 8'h00,      1'b0},
        '{CMD_CHAR, CHAR_PLUS,  CHK_MODEL, 8'h00,      1'b0},
        '{CMD_CHAR, CHAR_MINUS, CHK_MODEL, 8'h00,      1'b0},
        '{CMD_CHAR, CHAR_MUL,   CHK_NONE,  8'h00,      1'b0},
        '{CMD_CHAR, CHAR_DIV,   CHK_MODEL, 8'h00,      1'b0},
        '{CMD_CHAR, CHAR_MOD,   CHK_MODEL, 8'h00,      1'b0},
        '{CMD_CHAR, CHAR_POW,   CHK_NONE,  8'h00,      1'b0},
        '{CMD_CHAR, CHAR_POW,   CHK_NONE,  8'h00,      1'b0},
        '{CMD_CHAR, CHAR_OPEN,  CHK_NONE,  8'h00,      1'b0},
        '{CMD_CHAR, "b",        CHK_ONE,   "b",        1'b0},
        '{CMD_CHAR, CHAR_PLUS,  CHK_NONE,  8'h00,      1'b0},
        '{CMD_CHAR, "c",        CHK_ONE,   "c",        1'b0},
        '{CMD_CHAR, CHAR_CLOSE, CHK_ONE,   CHAR_PLUS,  1'b0},
        '{CMD_CHAR, CHAR_CLOSE, CHK_MODEL, 8'h00,      1'b0},
        '{CMD_END,  8'h5A,      CHK_MODEL, 8'h00,      1'b0}
    };

    infix_beat_t   stim_q [$];
    postfix_beat_t pending_postfix [$];

    // predictor state
    char_t opstack [STACK_DEPTH];
    int    op_level;
    logic  sticky_err;

    int fails;
    int infix_cnt;
    int postfix_cnt;
    int expr_cnt;
    int overflow_cnt;
    int unmatched_cnt;

    function automatic int op_rank(input char_t c);
        case (c)
            CHAR_OPEN:                    return 0;
            CHAR_PLUS, CHAR_MINUS:        return 1;
            CHAR_MUL, CHAR_DIV, CHAR_MOD: return 2;
            default:                      return 3;
        endcase
    endfunction

    function automatic logic is_operand(input char_t c);
        return c inside {[CHAR_0:CHAR_9], [CHAR_UA:CHAR_UZ], [CHAR_LA:CHAR_LZ]};
    endfunction

    function automatic postfix_beat_t plain_beat(input char_t c);
        return '{out_char: c, last: 1'b0, err: 1'b0};
    endfunction

    // push onto the predicted stack, a full stack drops it and flags
    function automatic void push_operator(input char_t c);
        if (op_level >= STACK_DEPTH)
        begin
            sticky_err = 1'b1;
            overflow_cnt++;
        end
        else
        begin
            opstack[op_level] = c;
            op_level++;
        end
    endfunction

    // postfix beats caused by one infix beat
    function automatic void shunt_step(input logic cmd, input char_t c,
                                       ref postfix_beat_t res [$]);
        char_t top;
        logic  found;
        logic  err_out;
        int    rank;
        int    top_rank;
        res.delete();
        if (cmd == CMD_END)
        begin
            while (op_level > 0)
            begin
                op_level--;
                res.push_back(plain_beat(opstack[op_level]));
            end
            res.push_back(plain_beat(CHAR_NL));
            err_out    = sticky_err;
            sticky_err = 1'b0;
        end
        else
        begin
            if (is_operand(c))
                res.push_back(plain_beat(c));
            else if (c == CHAR_OPEN)
                push_operator(c);
            else if (c == CHAR_CLOSE)
            begin
                found = 1'b0;
                while (op_level > 0 && !found)
                begin
                    op_level--;
                    top = opstack[op_level];
                    if (top == CHAR_OPEN)
                        found = 1'b1;
                    else
                        res.push_back(plain_beat(top));
                end
                if (!found)
                begin
                    sticky_err = 1'b1;
                    unmatched_cnt++;
                end
            end
            else
            begin
                rank = op_rank(c);
                while (op_level > 0)
                begin
                    top_rank = op_rank(opstack[op_level-1]);
                    // '$' binds to the right, so equal rank stays put
                    if ((c == CHAR_POW) ? (top_rank > rank) : (top_rank >= rank))
                    begin
                        op_level--;
                        res.push_back(plain_beat(opstack[op_level]));
                    end
                    else
                        break;
                end
                push_operator(c);
            end
            err_out = sticky_err;
        end
        foreach (res[k])
        begin
            res[k].last = (k == res.size() - 1);
            res[k].err  = err_out;
        end
    endfunction

    // stimulus builders
    function automatic void add_beat(input logic cmd, input char_t c);
        stim_q.push_back('{cmd, c, CHK_MODEL, 8'h00, 1'b0});
    endfunction

    function automatic char_t rand_operand();
        case ($urandom_range(0, 2))
            0:       return CHAR_0 + char_t'($urandom_range(0, 9));
            1:       return CHAR_UA + char_t'($urandom_range(0, 25));
            default: return CHAR_LA + char_t'($urandom_range(0, 25));
        endcase
    endfunction

    function automatic char_t rand_operator();
        char_t c;
        case ($urandom_range(0, 7))
            0:       c = CHAR_PLUS;
            1:       c = CHAR_MINUS;
            2:       c = CHAR_MUL;
            3:       c = CHAR_DIV;
            4:       c = CHAR_MOD;
            5:       c = CHAR_POW;
            default:
            begin
                // any byte but a letter, digit or bracket; one that is no named operator ranks highest
                c = char_t'($urandom_range(0, 255));
                while (is_operand(c) || c == CHAR_OPEN || c == CHAR_CLOSE)
                    c = char_t'($urandom_range(0, 255));
            end
        endcase
        return c;
    endfunction

    // a balanced expression, optionally spoilt
    function automatic void add_expression(input logic spoil);
        int depth;
        int nterms;
        depth  = 0;
        nterms = $urandom_range(1, 8);
        for (int t = 0; t < nterms; t++)
        begin
            while (depth < 6 && $urandom_range(0, 3) == 0)
            begin
                add_beat(CMD_CHAR, CHAR_OPEN);
                depth++;
            end
            add_beat(CMD_CHAR, rand_operand());
            while (depth > 0 && $urandom_range(0, 2) == 0)
            begin
                add_beat(CMD_CHAR, CHAR_CLOSE);
                depth--;
            end
            if (t != nterms - 1)
                add_beat(CMD_CHAR, rand_operator());
        end
        if (!spoil || $urandom_range(0, 2) != 0)
            repeat (depth) add_beat(CMD_CHAR, CHAR_CLOSE);
        if (spoil)
        begin
            case ($urandom_range(0, 1))
                0:       repeat ($urandom_range(1, 3)) add_beat(CMD_CHAR, CHAR_CLOSE);
                default: add_beat(CMD_CHAR, char_t'($urandom_range(0, 255)));
            endcase
        end
        add_beat(CMD_END, char_t'($urandom_range(0, 255)));
    endfunction

    // 30 to 40 pushes, running the stack past full when more than STACK_DEPTH
    function automatic void add_deep_nest();
        repeat ($urandom_range(30, 40))
        begin
            case ($urandom_range(0, 2))
                0:       add_beat(CMD_CHAR, CHAR_OPEN);
                1:       add_beat(CMD_CHAR, CHAR_POW);
                default:
                begin
                    add_beat(CMD_CHAR, rand_operand());
                    add_beat(CMD_CHAR, CHAR_OPEN);
                end
            endcase
        end
        add_beat(CMD_CHAR, rand_operand());
        repeat ($urandom_range(0, 4)) add_beat(CMD_CHAR, CHAR_CLOSE);
        add_beat(CMD_END, char_t'($urandom_range(0, 255)));
    endfunction

    // receiver stalls, switching between patterns
    initial
    begin : rx_stall
        int   mode;
        int   span;
        int   cnt;
        int   hold;
        logic r;
        char_out.ready = 1'b0;
        hold = 0;
        r    = 1'b1;
        cnt  = 0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(32, 200);
            repeat (span)
            begin
                @(posedge clk);
                cnt++;
                case (mode)
                    0: r = 1'b1;
                    1: r = 1'($urandom_range(0, 1));
                    2: r = (cnt % 7) >= 3;
                    default:
                    begin
                        if (hold == 0)
                        begin
                            r    = ~r;
                            hold = $urandom_range(1, 20);
                        end
                        hold--;
                    end
                endcase
                char_out.ready <= r;
            end
        end
    end

    // scoreboard: check outputs first, then predict from the accepted input
    always @(posedge clk)
    begin : scoreboard
        postfix_beat_t want;
        postfix_beat_t model_out [$];
        infix_beat_t   row;
        if (rst_n)
        begin
            if (char_out.valid && char_out.ready)
            begin
                postfix_cnt++;
                if (pending_postfix.size() == 0)
                begin
                    $error("unexpected postfix beat: out_char %02h last %b error %b",
                           char_out.out_char, char_out.last, char_out.error);
                    fails++;
                end
                else
                begin
                    want = pending_postfix.pop_front();
                    if (char_out.out_char !== want.out_char)
                    begin
                        $error("out_char: expected %02h, got %02h",
                               want.out_char, char_out.out_char);
                        fails++;
                    end
                    if (char_out.last !== want.last)
                    begin
                        $error("last: expected %b, got %b", want.last, char_out.last);
                        fails++;
                    end
                    if (char_out.error !== want.err)
                    begin
                        $error("error: expected %b, got %b", want.err, char_out.error);
                        fails++;
                    end
                end
            end
            if (char_in.valid && char_in.ready)
            begin
                row = stim_q[infix_cnt];
                infix_cnt++;
                if (char_in.cmd == CMD_END)
                    expr_cnt++;
                shunt_step(char_in.cmd, char_in.in_char, model_out);
                case (row.chk)
                    CHK_MODEL: foreach (model_out[k]) pending_postfix.push_back(model_out[k]);
                    CHK_ONE:   pending_postfix.push_back('{row.exp_char, 1'b1, row.exp_err});
                    default:   ;
                endcase
            end
        end
    end

    // sender: bursts with random gaps, then drain and report
    initial
    begin : sender
        int burst_left;
        int gap;
        int seq_idx;
        char_in.valid   = 1'b0;
        char_in.cmd     = CMD_CHAR;
        char_in.in_char = 8'h00;
        rst_n           = 1'b0;
        op_level        = 0;
        sticky_err      = 1'b0;
        fails           = 0;
        infix_cnt       = 0;
        postfix_cnt     = 0;
        expr_cnt        = 0;
        overflow_cnt    = 0;
        unmatched_cnt   = 0;

        foreach (directed_tbl[i])
            stim_q.push_back(directed_tbl[i]);
        seq_idx = 0;
        while (stim_q.size() < DIR_N + RANDOM_GOAL)
        begin
            if (seq_idx % 10 == 2)
                add_deep_nest();
            else
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2:    add_expression(1'b1);
                    3, 4, 5:
                    begin
                        repeat ($urandom_range(1, 12))
                            add_beat(($urandom_range(0, 7) == 0) ? CMD_END : CMD_CHAR,
                                     char_t'($urandom_range(0, 255)));
                    end
                    default:    add_expression(1'b0);
                endcase
            end
            seq_idx++;
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        burst_left = 0;
        foreach (stim_q[i])
        begin
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0)
                begin
                    char_in.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = (gap == 0) ? $urandom_range(16, 64) : $urandom_range(1, 24);
            end
            char_in.valid   <= 1'b1;
            char_in.cmd     <= stim_q[i].cmd;
            char_in.in_char <= stim_q[i].ch;
            do
                @(posedge clk);
            while (!char_in.ready);
            burst_left--;
        end
        char_in.valid <= 1'b0;

        // let the last accepted beat reach the predictor, drain, then allow for a stray beat
        @(posedge clk);
        while (pending_postfix.size() != 0)
            @(posedge clk);
        repeat (48) @(posedge clk);

        $display("run covered %0d infix beats in %0d expressions and %0d postfix beats",
                 infix_cnt, expr_cnt, postfix_cnt);
        $display("stack overflows seen %0d, unmatched closing brackets seen %0d",
                 overflow_cnt, unmatched_cnt);
        if (fails == 0)
            $display("[infix_to_postfix_converter] OK");
        else
            $display("[infix_to_postfix_converter] ERROR");
        $finish;
    end

    // watchdog
    initial
    begin : watchdog
        #15_000_000;
        $display("[infix_to_postfix_converter] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ----- infix_to_postfix_converter.f -----
rtl/itp_pkg.sv
rtl/itp_in_if.sv
rtl/itp_out_if.sv
rtl/itp_stack.sv
rtl/infix_to_postfix_converter.sv
tb/tb_infix_to_postfix_converter.sv
